@@ hdl/pcs_pkg.sv @@
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared constants, codes and types of the piecewise-constant CDF sampler.
// ----------------------------------------------------------------------------
package pcs_pkg;

    // Default sizing of the table.
    localparam int MAX_BINS_DEF    = 256;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed widths of the channel fields.
    localparam int REQ_W    = 2;
    localparam int INDEX_W  = 8;
    localparam int WIN_W    = 16;
    localparam int U_W      = 24;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 24;
    localparam int PDF_W    = 32;
    localparam int CFG_W    = 9;

    // Bin count after reset.
    localparam int COUNT_RESET = 256;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CONT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DISC = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNBUILT = 2'd2;

    // Divider operand selection.
    typedef logic [2:0] div_sel_t;
    localparam div_sel_t DIV_MEAN   = 3'd0;
    localparam div_sel_t DIV_D      = 3'd1;
    localparam div_sel_t DIV_POS    = 3'd2;
    localparam div_sel_t DIV_PDF_C  = 3'd3;
    localparam div_sel_t DIV_PDF_D  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                ld_wr;
        logic                build_start;
        logic                bld_rd;
        logic                bld_wr;
        logic                bld_end;
        logic                bld_fin;
        logic                clr_built;
        logic                res_clr;
        logic [STATUS_W-1:0] res_code;
        logic                q_start;
        logic                srch_rd;
        logic                srch_upd;
        logic                fetch_rd;
        logic                fetch_lat;
        logic                d_zero;
        logic                d_lat;
        logic                div_start;
        div_sel_t            div_sel;
        logic                set_pos;
        logic                set_pdf;
        logic                out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic built;
        logic total_zero;
        logic build_more;
        logic search_more;
        logic wb_zero;
        logic div_busy;
    } stat_t;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  bin_index;
        logic [POS_W-1:0]    position_q24;
        logic [PDF_W-1:0]    pdf_q16;
        logic [PDF_W-1:0]    integral_q16;
    } res_t;

endpackage

@@ hdl/pcs_req_if.sv @@
// ----------------------------------------------------------------------------
// pcs_req_if
// Request channel: load items and sample queries with valid/ready transfer.
// ----------------------------------------------------------------------------
interface pcs_req_if;
    logic                         valid;
    logic                         ready;
    logic [pcs_pkg::REQ_W-1:0]    req_type;
    logic [pcs_pkg::INDEX_W-1:0]  entry_index;
    logic [pcs_pkg::WIN_W-1:0]    weight;
    logic                         last_entry;
    logic [pcs_pkg::U_W-1:0]      u_q24;

    modport source (output valid, req_type, entry_index, weight, last_entry, u_q24,
                    input ready);
    modport sink   (input valid, req_type, entry_index, weight, last_entry, u_q24,
                    output ready);
endinterface

@@ hdl/pcs_res_if.sv @@
// ----------------------------------------------------------------------------
// pcs_res_if
// Result channel: one result item per request with valid/ready transfer.
// ----------------------------------------------------------------------------
interface pcs_res_if;
    logic                          valid;
    logic                          ready;
    logic [pcs_pkg::STATUS_W-1:0]  status;
    logic [pcs_pkg::INDEX_W-1:0]   bin_index;
    logic [pcs_pkg::POS_W-1:0]     position_q24;
    logic [pcs_pkg::PDF_W-1:0]     pdf_q16;
    logic [pcs_pkg::PDF_W-1:0]     integral_q16;

    modport source (output valid, status, bin_index, position_q24, pdf_q16, integral_q16,
                    input ready);
    modport sink   (input valid, status, bin_index, position_q24, pdf_q16, integral_q16,
                    output ready);
endinterface

@@ hdl/pcs_div.sv @@
// ----------------------------------------------------------------------------
// pcs_div
// Restoring divider: one quotient bit per cycle, NUM_W quotient bits per division.
// ----------------------------------------------------------------------------
module pcs_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    // Trial subtraction of the shifted remainder.
    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    // Control: counts the quotient bits still to produce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
endmodule

@@ hdl/pcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcs_ctrl
// Controller: sequences loads, the table build and the sample queries.
// ----------------------------------------------------------------------------
module pcs_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [pcs_pkg::REQ_W-1:0]  in_req_type,
    input  logic                       in_last,
    output logic                       in_ready,
    input  logic                       out_free,
    input  pcs_pkg::stat_t             stat,
    output pcs_pkg::cmd_t              cmd
);
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_BLD_RD    = 4'd1;
    localparam logic [3:0] S_BLD_WR    = 4'd2;
    localparam logic [3:0] S_MEAN_WAIT = 4'd3;
    localparam logic [3:0] S_SRCH      = 4'd4;
    localparam logic [3:0] S_SRCH_CMP  = 4'd5;
    localparam logic [3:0] S_FETCH     = 4'd6;
    localparam logic [3:0] S_Q_D       = 4'd7;
    localparam logic [3:0] S_D_WAIT    = 4'd8;
    localparam logic [3:0] S_Q_POS     = 4'd9;
    localparam logic [3:0] S_POS_WAIT  = 4'd10;
    localparam logic [3:0] S_Q_PDF     = 4'd11;
    localparam logic [3:0] S_PDF_WAIT  = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       cont_reg, cont_next;

    // State and query mode registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cont_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cont_reg  <= cont_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cont_next  = cont_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_req_type)
                        pcs_pkg::REQ_LOAD:
                        begin
                            cmd.ld_wr = 1'b1;
                            if (in_last)
                            begin
                                cmd.build_start = 1'b1;
                                state_next      = S_BLD_RD;
                            end
                            else
                            begin
                                cmd.clr_built = 1'b1;
                                cmd.res_clr   = 1'b1;
                                cmd.res_code  = pcs_pkg::ST_UNBUILT;
                                state_next    = S_DONE;
                            end
                        end
                        pcs_pkg::REQ_CONT, pcs_pkg::REQ_DISC:
                        begin
                            cont_next = (in_req_type == pcs_pkg::REQ_CONT);
                            if (!stat.built)
                            begin
                                cmd.res_clr  = 1'b1;
                                cmd.res_code = pcs_pkg::ST_UNBUILT;
                                state_next   = S_DONE;
                            end
                            else if (stat.total_zero)
                            begin
                                cmd.res_clr  = 1'b1;
                                cmd.res_code = pcs_pkg::ST_ZERO;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                cmd.q_start = 1'b1;
                                state_next  = S_SRCH;
                            end
                        end
                        default:
                        begin
                            cmd.res_clr  = 1'b1;
                            cmd.res_code = pcs_pkg::ST_OK;
                            state_next   = S_DONE;
                        end
                    endcase
                end
            end
            S_BLD_RD:
            begin
                if (stat.build_more)
                begin
                    cmd.bld_rd = 1'b1;
                    state_next = S_BLD_WR;
                end
                else
                begin
                    cmd.bld_end   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = pcs_pkg::DIV_MEAN;
                    state_next    = S_MEAN_WAIT;
                end
            end
            S_BLD_WR:
            begin
                cmd.bld_wr = 1'b1;
                state_next = S_BLD_RD;
            end
            S_MEAN_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.bld_fin = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_SRCH:
            begin
                if (stat.search_more)
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRCH_CMP;
                end
                else
                begin
                    cmd.fetch_rd = 1'b1;
                    state_next   = S_FETCH;
                end
            end
            S_SRCH_CMP:
            begin
                cmd.srch_upd = 1'b1;
                state_next   = S_SRCH;
            end
            S_FETCH:
            begin
                cmd.fetch_lat = 1'b1;
                state_next    = S_Q_D;
            end
            S_Q_D:
            begin
                if (!cont_reg)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = pcs_pkg::DIV_PDF_D;
                    state_next    = S_PDF_WAIT;
                end
                else if (stat.wb_zero)
                begin
                    cmd.d_zero = 1'b1;
                    state_next = S_Q_POS;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = pcs_pkg::DIV_D;
                    state_next    = S_D_WAIT;
                end
            end
            S_D_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.d_lat  = 1'b1;
                    state_next = S_Q_POS;
                end
            end
            S_Q_POS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = pcs_pkg::DIV_POS;
                state_next    = S_POS_WAIT;
            end
            S_POS_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.set_pos = 1'b1;
                    state_next  = S_Q_PDF;
                end
            end
            S_Q_PDF:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = pcs_pkg::DIV_PDF_C;
                state_next    = S_PDF_WAIT;
            end
            S_PDF_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.set_pdf = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

@@ hdl/pcs_dp.sv @@
// ----------------------------------------------------------------------------
// pcs_dp
// Datapath: weight and prefix-sum memories, search, divider and result.
// ----------------------------------------------------------------------------
module pcs_dp #(
    parameter int MAX_BINS    = pcs_pkg::MAX_BINS_DEF,
    parameter int WEIGHT_BITS = pcs_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pcs_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [pcs_pkg::INDEX_W-1:0]   in_entry_index,
    input  logic [pcs_pkg::WIN_W-1:0]     in_weight,
    input  logic [pcs_pkg::U_W-1:0]       in_u_q24,
    input  pcs_pkg::cmd_t                 cmd,
    output pcs_pkg::stat_t                stat,
    output pcs_pkg::res_t                 res
);
    localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W  = $clog2(MAX_BINS + 1);
    localparam int SUM_W  = WEIGHT_BITS + IDX_W;
    localparam int TGT_W  = SUM_W + pcs_pkg::U_W;
    localparam int NUM_W  = WEIGHT_BITS + CNT_W + 24;
    localparam int DEN_W  = SUM_W;
    localparam int D_W    = 25;
    localparam int N_RST  = (pcs_pkg::COUNT_RESET > MAX_BINS) ? MAX_BINS
                                                              : pcs_pkg::COUNT_RESET;

    // Memories and their registered read data.
    logic [WEIGHT_BITS-1:0] wmem [MAX_BINS];
    logic [SUM_W-1:0]       smem [MAX_BINS+1];
    logic [WEIGHT_BITS-1:0] w_rdata;
    logic [SUM_W-1:0]       s_rdata;

    // Control state.
    logic             built_reg;
    logic [SUM_W-1:0] total_reg;
    logic [CNT_W-1:0] n_reg;
    logic [31:0]      mean_reg;

    // Working registers.
    logic [CNT_W-1:0]       i_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic [TGT_W-1:0]       target_reg;
    logic [CNT_W-1:0]       lo_reg, hi_reg;
    logic [IDX_W-1:0]       bin_reg;
    logic [WEIGHT_BITS-1:0] wb_reg;
    logic [SUM_W-1:0]       sb_reg;
    logic [D_W-1:0]         d_reg;
    pcs_pkg::res_t          res_reg;

    logic [SUM_W-1:0]             acc_next;
    logic [CNT_W:0]               lh_sum;
    logic [CNT_W-1:0]             mid;
    logic [IDX_W-1:0]             bin;
    logic [TGT_W-1:0]             tgt_mul;
    logic [WEIGHT_BITS+CNT_W-1:0] wn_mul;
    logic                         idx_ok;
    logic [31:0]                  cfg_ext;
    logic [31:0]                  cnt_clamp;
    logic [NUM_W-1:0]             div_num;
    logic [DEN_W-1:0]             div_den;
    logic                         div_busy;
    logic [NUM_W-1:0]             quot;
    logic [31:0]                  quot_sat32;
    logic [pcs_pkg::POS_W-1:0]    quot_sat24;

    // Combinational helpers.
    assign acc_next   = acc_reg + SUM_W'(w_rdata);
    assign lh_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = lh_sum[CNT_W:1];
    assign bin        = (lo_reg == '0) ? '0 : IDX_W'(lo_reg - 1'b1);
    assign tgt_mul    = TGT_W'(in_u_q24) * TGT_W'(total_reg);
    assign wn_mul     = (WEIGHT_BITS+CNT_W)'(wb_reg) * (WEIGHT_BITS+CNT_W)'(n_reg);
    assign idx_ok     = (32'(in_entry_index) < 32'(MAX_BINS));
    assign cfg_ext    = 32'(cfg_wdata);
    assign cnt_clamp  = (cfg_ext == 32'd0) ? 32'd1 :
                        (cfg_ext > 32'(MAX_BINS)) ? 32'(MAX_BINS) : cfg_ext;
    assign quot_sat32 = (|quot[NUM_W-1:32]) ? '1 : quot[31:0];
    assign quot_sat24 = (|quot[NUM_W-1:24]) ? '1 : quot[23:0];

    // Weight memory: written by loads, read by the build and the fetch.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_wr && idx_ok)
        begin
            wmem[IDX_W'(in_entry_index)] <= WEIGHT_BITS'(in_weight);
        end
        if (cmd.bld_rd)
        begin
            w_rdata <= wmem[i_reg[IDX_W-1:0]];
        end
        else if (cmd.fetch_rd)
        begin
            w_rdata <= wmem[bin];
        end
    end

    // Prefix-sum memory: written by the build, read by the search and fetch.
    always_ff @(posedge clk)
    begin
        if (cmd.build_start)
        begin
            smem[0] <= '0;
        end
        else if (cmd.bld_wr)
        begin
            smem[CNT_W'(i_reg + 1'b1)] <= acc_next;
        end
        if (cmd.srch_rd)
        begin
            s_rdata <= smem[mid];
        end
        else if (cmd.fetch_rd)
        begin
            s_rdata <= smem[CNT_W'(bin)];
        end
    end

    // Table state, bin count and mean.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            built_reg <= 1'b0;
            total_reg <= '0;
            n_reg     <= CNT_W'(N_RST);
            mean_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                n_reg     <= CNT_W'(cnt_clamp);
                built_reg <= 1'b0;
            end
            if (cmd.clr_built)
            begin
                built_reg <= 1'b0;
            end
            if (cmd.bld_end)
            begin
                total_reg <= acc_reg;
            end
            if (cmd.bld_fin)
            begin
                built_reg <= 1'b1;
                mean_reg  <= quot_sat32;
            end
        end
    end

    // Build, search and query working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.build_start)
        begin
            i_reg   <= '0;
            acc_reg <= '0;
        end
        if (cmd.bld_wr)
        begin
            i_reg   <= i_reg + 1'b1;
            acc_reg <= acc_next;
        end
        if (cmd.q_start)
        begin
            target_reg <= tgt_mul;
            lo_reg     <= '0;
            hi_reg     <= n_reg;
        end
        if (cmd.srch_upd)
        begin
            if ({s_rdata, 24'd0} >= target_reg)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid + 1'b1;
            end
        end
        if (cmd.fetch_rd)
        begin
            bin_reg <= bin;
        end
        if (cmd.fetch_lat)
        begin
            wb_reg <= w_rdata;
            sb_reg <= s_rdata;
        end
        if (cmd.d_zero)
        begin
            d_reg <= '0;
        end
        if (cmd.d_lat)
        begin
            d_reg <= quot[D_W-1:0];
        end
    end

    // Result staging.
    always_ff @(posedge clk)
    begin
        if (cmd.res_clr)
        begin
            res_reg <= '{status: cmd.res_code, bin_index: '0, position_q24: '0,
                         pdf_q16: '0, integral_q16: '0};
        end
        if (cmd.bld_fin)
        begin
            res_reg <= '{status: ((total_reg == '0) ? pcs_pkg::ST_ZERO : pcs_pkg::ST_OK),
                         bin_index: '0, position_q24: '0, pdf_q16: '0,
                         integral_q16: quot_sat32};
        end
        if (cmd.fetch_lat)
        begin
            res_reg <= '{status: pcs_pkg::ST_OK,
                         bin_index: pcs_pkg::INDEX_W'(bin_reg),
                         position_q24: '0, pdf_q16: '0, integral_q16: mean_reg};
        end
        if (cmd.set_pos)
        begin
            res_reg.position_q24 <= quot_sat24;
        end
        if (cmd.set_pdf)
        begin
            res_reg.pdf_q16 <= quot_sat32;
        end
    end

    // Divider operand selection.
    always_comb
    begin
        div_num = '0;
        div_den = '0;
        case (cmd.div_sel)
            pcs_pkg::DIV_MEAN:
            begin
                div_num = NUM_W'({acc_reg, 16'd0});
                div_den = DEN_W'(n_reg);
            end
            pcs_pkg::DIV_D:
            begin
                div_num = NUM_W'(target_reg - {sb_reg, 24'd0});
                div_den = DEN_W'(wb_reg);
            end
            pcs_pkg::DIV_POS:
            begin
                div_num = NUM_W'({bin_reg, 24'd0}) + NUM_W'(d_reg);
                div_den = DEN_W'(n_reg);
            end
            pcs_pkg::DIV_PDF_C:
            begin
                div_num = NUM_W'({wn_mul, 16'd0});
                div_den = total_reg;
            end
            pcs_pkg::DIV_PDF_D:
            begin
                div_num = NUM_W'({wb_reg, 16'd0});
                div_den = total_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    pcs_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (quot)
    );

    // Status towards the controller.
    assign stat.built       = built_reg;
    assign stat.total_zero  = (total_reg == '0);
    assign stat.build_more  = (i_reg < n_reg);
    assign stat.search_more = (lo_reg < hi_reg);
    assign stat.wb_zero     = (wb_reg == '0);
    assign stat.div_busy    = div_busy;

    assign res = res_reg;
endmodule

@@ hdl/piecewise_constant_cdf_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// piecewise_constant_cdf_sampler_unit
// Piecewise-constant 1D distribution with inverse-CDF sampling in fixed point.
// Load requests store bin weights; the load marked last builds the prefix-sum
// table and reports the mean weight. Sample requests binary-search the table
// and return the bin, the Q16.16 density and the Q0.24 position (continuous)
// or the bin and the Q16.16 probability (discrete). One request is worked on
// at a time and every request gives exactly one result; the next request is
// taken while the previous result still waits in the output register. All
// divisions go through one shared restoring divider of N = WEIGHT_BITS +
// clog2(MAX_BINS+1) + 24 bits (49 at the defaults). The last load walks every
// bin through the weight memory port to build the table, then runs one
// division for the mean. A query binary-searches the table through the
// prefix-sum memory port, then runs one division for a discrete query and
// two or three for a continuous one.
// ----------------------------------------------------------------------------
module piecewise_constant_cdf_sampler_unit #(
    parameter int MAX_BINS    = pcs_pkg::MAX_BINS_DEF,
    parameter int WEIGHT_BITS = pcs_pkg::WEIGHT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    pcs_req_if.sink                   req,
    pcs_res_if.source                 res,
    input  logic                      cfg_we,
    input  logic [pcs_pkg::CFG_W-1:0] cfg_wdata
);
    pcs_pkg::cmd_t  cmd;
    pcs_pkg::stat_t stat;
    pcs_pkg::res_t  dp_res;
    pcs_pkg::res_t  out_reg;
    logic           out_valid_reg;
    logic           out_free;
    logic           in_ready;

    assign out_free  = !out_valid_reg || res.ready;
    assign req.ready = in_ready;

    pcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_last     (req.last_entry),
        .in_ready    (in_ready),
        .out_free    (out_free),
        .stat        (stat),
        .cmd         (cmd)
    );

    pcs_dp #(
        .MAX_BINS    (MAX_BINS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_entry_index (req.entry_index),
        .in_weight      (req.weight),
        .in_u_q24       (req.u_q24),
        .cmd            (cmd),
        .stat           (stat),
        .res            (dp_res)
    );

    // Output register: holds a finished result until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= dp_res;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.status       = out_reg.status;
    assign res.bin_index    = out_reg.bin_index;
    assign res.position_q24 = out_reg.position_q24;
    assign res.pdf_q16      = out_reg.pdf_q16;
    assign res.integral_q16 = out_reg.integral_q16;

    // A result is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || res.ready))
        else $error("result loaded over a waiting result");

    // One request at a time: no transfer in the cycle after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in progress");

    // The divider is never restarted while it is working.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");
endmodule
